// ===== rtl/ptw_pkg.sv =====
// shared types and constants of the 4 KB granule page table walker
package ptw_pkg;

	localparam int unsigned ADDR_W    = 48;
	localparam int unsigned DESC_W    = 64;
	localparam int unsigned TAG_W     = 4;
	localparam int unsigned LVL_W     = 2;
	localparam int unsigned OFFSET_W  = 6;
	localparam int unsigned IDX_W     = 9;
	localparam int unsigned IN_DATA_W = 120;
	localparam int unsigned OUT_DATA_W = 64;

	localparam int unsigned TAG_SHIFT = 2;
	localparam int unsigned TAG_WIDTH = 4;
	localparam logic [DESC_W-1:0] TAG_MASK = DESC_W'((65'd1 << TAG_WIDTH) - 65'd1);

	localparam logic [OFFSET_W-1:0] VA_OFFSET_RESET = 6'd16;
	localparam logic [2:0] LEVEL_NONE = 3'b111;

	localparam logic [LVL_W-1:0] LVL_0 = 2'd0;
	localparam logic [LVL_W-1:0] LVL_1 = 2'd1;
	localparam logic [LVL_W-1:0] LVL_2 = 2'd2;
	localparam logic [LVL_W-1:0] LVL_3 = 2'd3;

	typedef enum logic [0:0] {
		OP_START    = 1'b0,
		OP_RESPONSE = 1'b1
	} opcode_t;

	typedef enum logic [0:0] {
		REG_TABLE_BASE     = 1'b0,
		REG_VA_SIZE_OFFSET = 1'b1
	} reg_index_t;

	typedef enum logic [2:0] {
		ST_REQUEST    = 3'd0,
		ST_TRANSLATED = 3'd1,
		ST_FAULT      = 3'd2,
		ST_RESERVED   = 3'd3,
		ST_UNREADABLE = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		K_START   = 3'd0,
		K_FAIL    = 3'd1,
		K_INVALID = 3'd2,
		K_TABLE   = 3'd3,
		K_BLOCK   = 3'd4
	} kind_t;

	typedef struct packed {
		logic       read_only;
		logic       user_no_exec;
		logic       priv_no_exec;
		logic       not_global;
		logic       access_flag;
		logic [1:0] shareability;
	} attr_t;

	typedef struct packed {
		kind_t              kind;
		logic [LVL_W-1:0]   start_lvl;
		logic [ADDR_W-1:0]  addr;
		logic [TAG_W-1:0]   tag;
		attr_t              attr;
	} entry_t;

	typedef struct packed {
		status_t            status;
		logic [ADDR_W-1:0]  address;
		logic [TAG_W-1:0]   tag;
		logic [2:0]         level;
		attr_t              attr;
	} result_t;

endpackage

// ===== rtl/ptw_front.sv =====
// request intake: decodes opcode and descriptor kind into a queue entry
module ptw_front (
	input  logic                               tvalid,
	output logic                               tready,
	input  logic                               tuser,
	input  logic [ptw_pkg::IN_DATA_W-1:0]      tdata,
	input  logic [ptw_pkg::OFFSET_W-1:0]       va_size_offset,
	input  logic                               full,
	output logic                               push,
	output ptw_pkg::entry_t                    entry
);

	logic [ptw_pkg::ADDR_W-1:0] vaddr;
	logic [ptw_pkg::DESC_W-1:0] desc;
	logic [ptw_pkg::DESC_W-1:0] tag_raw;
	logic                       read_failed;

	assign vaddr       = tdata[47:0];
	assign desc        = tdata[111:48];
	assign read_failed = tdata[112];
	assign tag_raw     = (desc >> ptw_pkg::TAG_SHIFT) & ptw_pkg::TAG_MASK;

	assign tready = !full;
	assign push   = tvalid && !full;

	always_comb begin
		entry = '0;
		entry.tag = tag_raw[ptw_pkg::TAG_W-1:0];
		entry.attr.read_only    = desc[7];
		entry.attr.user_no_exec = desc[54];
		entry.attr.priv_no_exec = desc[53];
		entry.attr.not_global   = desc[11];
		entry.attr.access_flag  = desc[10];
		entry.attr.shareability = desc[9:8];
		// start level from va width 64 - offset
		priority if (va_size_offset < 6'd25) begin
			entry.start_lvl = ptw_pkg::LVL_0;
		end else if (va_size_offset < 6'd34) begin
			entry.start_lvl = ptw_pkg::LVL_1;
		end else if (va_size_offset < 6'd43) begin
			entry.start_lvl = ptw_pkg::LVL_2;
		end else begin
			entry.start_lvl = ptw_pkg::LVL_3;
		end
		if (tuser == ptw_pkg::OP_START) begin
			entry.kind = ptw_pkg::K_START;
			entry.addr = vaddr;
		end else begin
			entry.addr = {desc[47:12], 12'd0};
			priority if (read_failed) begin
				entry.kind = ptw_pkg::K_FAIL;
			end else if (!desc[0]) begin
				entry.kind = ptw_pkg::K_INVALID;
			end else if (desc[1]) begin
				entry.kind = ptw_pkg::K_TABLE;
			end else begin
				entry.kind = ptw_pkg::K_BLOCK;
			end
		end
	end

endmodule

// ===== rtl/ptw_queue.sv =====
// small register queue between intake and walk engine
module ptw_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ptw_pkg::entry_t wr_entry,
	input  logic            pop,
	output ptw_pkg::entry_t rd_entry,
	output logic            full,
	output logic            empty
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	ptw_pkg::entry_t mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/ptw_back.sv =====
// walk engine: holds walk state, builds read requests and results
module ptw_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [ptw_pkg::ADDR_W-1:0]     table_base,
	input  ptw_pkg::entry_t                entry,
	input  logic                           empty,
	output logic                           pop,
	output logic                           out_valid,
	input  logic                           out_ready,
	output ptw_pkg::result_t               out_result
);

	logic                          busy_q;
	logic [ptw_pkg::LVL_W-1:0]     level_q;
	logic [ptw_pkg::ADDR_W-1:0]    held_vaddr_q;
	logic [ptw_pkg::ADDR_W-1:0]    table_q;
	logic                          out_valid_q;
	ptw_pkg::result_t              out_q;

	logic                          is_start;
	logic                          descend;
	logic [ptw_pkg::LVL_W-1:0]     req_lvl;
	logic [ptw_pkg::ADDR_W-1:0]    req_vaddr;
	logic [ptw_pkg::ADDR_W-1:0]    req_base;
	logic [ptw_pkg::IDX_W-1:0]     req_idx;
	logic [ptw_pkg::ADDR_W-1:0]    req_addr;
	logic [ptw_pkg::ADDR_W-1:0]    leaf_mask;
	logic                          res_valid;
	logic                          ends_walk;
	ptw_pkg::result_t              res;

	assign pop       = !empty && (!out_valid_q || out_ready);
	assign is_start  = (entry.kind == ptw_pkg::K_START);
	assign descend   = busy_q && (entry.kind == ptw_pkg::K_TABLE) &&
		(level_q != ptw_pkg::LVL_3);
	assign req_lvl   = is_start ? entry.start_lvl : level_q + 1'b1;
	assign req_vaddr = is_start ? entry.addr : held_vaddr_q;
	assign req_base  = is_start ? table_base : entry.addr;
	assign req_addr  = req_base + {36'd0, req_idx, 3'd0};

	always_comb begin
		unique case (req_lvl)
			ptw_pkg::LVL_0: req_idx = req_vaddr[47:39];
			ptw_pkg::LVL_1: req_idx = req_vaddr[38:30];
			ptw_pkg::LVL_2: req_idx = req_vaddr[29:21];
			default:        req_idx = req_vaddr[20:12];
		endcase
		unique case (level_q)
			ptw_pkg::LVL_0: leaf_mask = 48'h007F_FFFF_FFFF;
			ptw_pkg::LVL_1: leaf_mask = 48'h0000_3FFF_FFFF;
			ptw_pkg::LVL_2: leaf_mask = 48'h0000_001F_FFFF;
			default:        leaf_mask = 48'h0000_0000_0FFF;
		endcase
	end

	always_comb begin
		res       = '0;
		res_valid = 1'b1;
		ends_walk = 1'b1;
		res.level = {1'b0, level_q};
		if (is_start || descend) begin
			res.status = ptw_pkg::ST_REQUEST;
			res.address = req_addr;
			res.level = {1'b0, req_lvl};
			ends_walk = 1'b0;
		end else if (!busy_q) begin
			res_valid = 1'b0;
			ends_walk = 1'b0;
		end else begin
			unique case (entry.kind)
				ptw_pkg::K_FAIL: begin
					res.status = ptw_pkg::ST_UNREADABLE;
					res.level = ptw_pkg::LEVEL_NONE;
				end
				ptw_pkg::K_INVALID: begin
					res.status = ptw_pkg::ST_FAULT;
					res.tag = entry.tag;
				end
				ptw_pkg::K_BLOCK: begin
					if (level_q == ptw_pkg::LVL_3) begin
						res.status = ptw_pkg::ST_RESERVED;
					end else begin
						res.status = ptw_pkg::ST_TRANSLATED;
						res.address = entry.addr | (held_vaddr_q & leaf_mask);
						res.attr = entry.attr;
					end
				end
				default: begin
					// page at level 3
					res.status = ptw_pkg::ST_TRANSLATED;
					res.address = entry.addr | (held_vaddr_q & leaf_mask);
					res.attr = entry.attr;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			level_q      <= '0;
			held_vaddr_q <= '0;
			table_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (pop) begin
				if (is_start || descend) begin
					busy_q  <= 1'b1;
					level_q <= req_lvl;
					table_q <= req_base;
				end else if (ends_walk) begin
					busy_q <= 1'b0;
				end
				if (is_start) begin
					held_vaddr_q <= entry.addr;
				end
			end
			if (pop && res_valid) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_result = out_q;

	a_start_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pop && is_start |=> busy_q)
		else $error("walk not busy after start");

	a_end_clears_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pop && res_valid && res.status != ptw_pkg::ST_REQUEST |=> !busy_q)
		else $error("walk still busy after final result");

	a_idle_response_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !busy_q && !is_start |-> !res_valid)
		else $error("result from response while idle");

	a_request_tracks_table: assert property (@(posedge clk) disable iff (!arst_n)
		pop && (is_start || descend) |=> table_q == $past(req_base))
		else $error("table base not captured with request");

endmodule

// ===== rtl/page_table_walker_4k_top.sv =====
// Page table walker for a 4 KB granule: intake, request queue and walk engine.
// An accepted request passes through the queue and the result register before its result shows.
// Throughput: one request per cycle while the queue has room; each response is resolved as the engine pops it.
// The result register lets intake continue while a result waits to be taken.
// Reset clears the walk, the queue and the result valid; table_base resets to 0,
// va_size_offset to 16.
module page_table_walker_4k_top #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [ptw_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // vaddr, descriptor, read_failed
	input  logic                               s_axis_tuser,  // opcode
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [ptw_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // address, tag, level, read_only,
	                                                          // user_no_exec, priv_no_exec,
	                                                          // not_global, access_flag,
	                                                          // shareability
	output logic [2:0]                         m_axis_tuser,  // status
	input  logic                               cfg_we,
	input  logic                               cfg_addr,
	input  logic [ptw_pkg::ADDR_W-1:0]         cfg_wdata
);

	logic [ptw_pkg::ADDR_W-1:0]   table_base_q;
	logic [ptw_pkg::OFFSET_W-1:0] va_size_offset_q;
	logic                         push;
	logic                         pop;
	logic                         full;
	logic                         empty;
	ptw_pkg::entry_t              wr_entry;
	ptw_pkg::entry_t              rd_entry;
	ptw_pkg::result_t             result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_base_q     <= '0;
			va_size_offset_q <= ptw_pkg::VA_OFFSET_RESET;
		end else if (cfg_we) begin
			unique case (ptw_pkg::reg_index_t'(cfg_addr))
				ptw_pkg::REG_TABLE_BASE:     table_base_q <= cfg_wdata;
				ptw_pkg::REG_VA_SIZE_OFFSET: va_size_offset_q <= cfg_wdata[ptw_pkg::OFFSET_W-1:0];
				default:                     table_base_q <= table_base_q;
			endcase
		end
	end

	ptw_front u_front (
		.tvalid         (s_axis_tvalid),
		.tready         (s_axis_tready),
		.tuser          (s_axis_tuser),
		.tdata          (s_axis_tdata),
		.va_size_offset (va_size_offset_q),
		.full           (full),
		.push           (push),
		.entry          (wr_entry)
	);

	ptw_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.rd_entry (rd_entry),
		.full     (full),
		.empty    (empty)
	);

	ptw_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.table_base (table_base_q),
		.entry      (rd_entry),
		.empty      (empty),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_result (result)
	);

	assign m_axis_tuser = result.status;
	assign m_axis_tdata = {2'b00, result.attr.shareability, result.attr.access_flag,
		result.attr.not_global, result.attr.priv_no_exec, result.attr.user_no_exec,
		result.attr.read_only, result.level, result.tag, result.address};

endmodule

// ===== test/page_table_walker_4k_checker.sv =====
`timescale 1ns / 100ps
// checker for the page table walker: tracks the walk on accepted requests and compares results
module page_table_walker_4k_checker
	import ptw_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	input  logic                    s_tready,
	input  logic [IN_DATA_W-1:0]    s_tdata,
	input  logic                    s_tuser,
	input  logic                    m_tvalid,
	input  logic                    m_tready,
	input  logic [OUT_DATA_W-1:0]   m_tdata,
	input  logic [2:0]              m_tuser,
	input  logic                    cfg_we,
	input  logic                    cfg_addr,
	input  logic [ADDR_W-1:0]       cfg_wdata,
	output int unsigned             errors,
	output int unsigned             pending,
	output int unsigned             results,
	output int unsigned             translations
);

	logic [ADDR_W-1:0]   base_reg;
	logic [OFFSET_W-1:0] offset_reg;
	logic                walking;
	logic [LVL_W-1:0]    cur_level;
	logic [ADDR_W-1:0]   walk_va;
	logic [ADDR_W-1:0]   cur_table;
	result_t             walk_results[$];

	initial begin
		errors = 0;
		pending = 0;
		results = 0;
		translations = 0;
	end

	function automatic logic [LVL_W-1:0] entry_level(logic [OFFSET_W-1:0] off);
		int unsigned va_bits;
		va_bits = 64 - off;
		if (va_bits > 39)
			return LVL_0;
		if (va_bits > 30)
			return LVL_1;
		if (va_bits > 21)
			return LVL_2;
		return LVL_3;
	endfunction

	// read of the descriptor indexed by the held address at the current level
	task automatic push_table_read();
		result_t r;
		logic [IDX_W-1:0] idx;
		r = '0;
		idx = IDX_W'(walk_va >> (39 - 9 * cur_level));
		r.status = ST_REQUEST;
		r.address = ADDR_W'(cur_table + (ADDR_W'(idx) << 3));
		r.level = {1'b0, cur_level};
		walk_results.push_back(r);
	endtask

	task automatic walk_step(opcode_t op, logic [ADDR_W-1:0] va, logic [DESC_W-1:0] desc,
			logic failed);
		result_t r;
		logic [ADDR_W-1:0] span_mask;
		r = '0;
		if (op == OP_START) begin
			walk_va = va;
			cur_level = entry_level(offset_reg);
			cur_table = base_reg;
			walking = 1'b1;
			push_table_read();
			return;
		end
		if (!walking)
			return;
		if (failed) begin
			walking = 1'b0;
			r.status = ST_UNREADABLE;
			r.level = LEVEL_NONE;
			walk_results.push_back(r);
			return;
		end
		if (!desc[0]) begin
			walking = 1'b0;
			r.status = ST_FAULT;
			r.tag = TAG_W'((desc >> TAG_SHIFT) & TAG_MASK);
			r.level = {1'b0, cur_level};
			walk_results.push_back(r);
			return;
		end
		if (cur_level == LVL_3 && desc[1:0] != 2'b11) begin
			walking = 1'b0;
			r.status = ST_RESERVED;
			r.level = {1'b0, LVL_3};
			walk_results.push_back(r);
			return;
		end
		if (cur_level != LVL_3 && desc[1:0] == 2'b11) begin
			cur_table = {desc[ADDR_W-1:12], 12'h000};
			cur_level = cur_level + 2'd1;
			push_table_read();
			return;
		end
		walking = 1'b0;
		span_mask = (ADDR_W'(1) << (39 - 9 * cur_level)) - ADDR_W'(1);
		r.status = ST_TRANSLATED;
		r.address = {desc[ADDR_W-1:12], 12'h000} | (walk_va & span_mask);
		r.level = {1'b0, cur_level};
		r.attr.read_only = desc[7];
		r.attr.user_no_exec = desc[54];
		r.attr.priv_no_exec = desc[53];
		r.attr.not_global = desc[11];
		r.attr.access_flag = desc[10];
		r.attr.shareability = desc[9:8];
		walk_results.push_back(r);
	endtask

	task automatic check_field(string what, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s expected %h, got %h", $time, what, want, got);
		end
	endtask

	task automatic check_result();
		result_t want;
		results++;
		if (walk_results.size() == 0) begin
			errors++;
			$display("%0t: unexpected result, status %0d address %h", $time, m_tuser,
				m_tdata[47:0]);
			return;
		end
		want = walk_results.pop_front();
		if (want.status == ST_TRANSLATED)
			translations++;
		check_field("status", ADDR_W'(want.status), ADDR_W'(m_tuser));
		check_field("address", want.address, m_tdata[47:0]);
		check_field("tag", ADDR_W'(want.tag), ADDR_W'(m_tdata[51:48]));
		check_field("level", ADDR_W'(want.level), ADDR_W'(m_tdata[54:52]));
		check_field("read_only", ADDR_W'(want.attr.read_only), ADDR_W'(m_tdata[55]));
		check_field("user_no_exec", ADDR_W'(want.attr.user_no_exec), ADDR_W'(m_tdata[56]));
		check_field("priv_no_exec", ADDR_W'(want.attr.priv_no_exec), ADDR_W'(m_tdata[57]));
		check_field("not_global", ADDR_W'(want.attr.not_global), ADDR_W'(m_tdata[58]));
		check_field("access_flag", ADDR_W'(want.attr.access_flag), ADDR_W'(m_tdata[59]));
		check_field("shareability", ADDR_W'(want.attr.shareability), ADDR_W'(m_tdata[61:60]));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_reg = '0;
			offset_reg = VA_OFFSET_RESET;
			walking = 1'b0;
			cur_level = LVL_0;
			walk_va = '0;
			cur_table = '0;
			walk_results.delete();
		end else begin
			if (m_tvalid && m_tready)
				check_result();
			if (cfg_we) begin
				if (reg_index_t'(cfg_addr) == REG_TABLE_BASE)
					base_reg = cfg_wdata;
				else
					offset_reg = cfg_wdata[OFFSET_W-1:0];
			end
			if (s_tvalid && s_tready)
				walk_step(opcode_t'(s_tuser), s_tdata[47:0], s_tdata[111:48], s_tdata[112]);
		end
		pending = walk_results.size();
	end

endmodule

// ===== test/page_table_walker_4k_top_test.sv =====
`timescale 1ns / 100ps
// testbench top for the page table walker: stimulus, register phases and verdict
module page_table_walker_4k_top_test;
	import ptw_pkg::*;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;  // vaddr, descriptor, read_failed
	logic                  s_axis_tuser = 1'b0;  // opcode
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;  // address, tag, level, read_only, user_no_exec,
	                                      // priv_no_exec, not_global, access_flag,
	                                      // shareability
	logic [2:0]            m_axis_tuser;  // status
	logic                  cfg_we = 1'b0;
	logic                  cfg_addr = 1'b0;
	logic [ADDR_W-1:0]     cfg_wdata = '0;

	int unsigned errors, pending, results, translations;
	int unsigned sent = 0;
	int unsigned walks = 0;
	int unsigned phases = 0;
	logic [OFFSET_W-1:0] cur_off = VA_OFFSET_RESET;
	logic walk_open = 1'b0;
	logic steady = 1'b0;
	logic hold_go = 1'b0;
	logic hold_done = 1'b0;
	int unsigned hold_left = 0;

	page_table_walker_4k_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	page_table_walker_4k_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_axis_tvalid),
		.s_tready(s_axis_tready),
		.s_tdata(s_axis_tdata),
		.s_tuser(s_axis_tuser),
		.m_tvalid(m_axis_tvalid),
		.m_tready(m_axis_tready),
		.m_tdata(m_axis_tdata),
		.m_tuser(m_axis_tuser),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.errors(errors),
		.pending(pending),
		.results(results),
		.translations(translations)
	);

	always #1 clk = ~clk;

	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

	// result side: random stalls plus one long hold-off
	initial begin
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready = 1'b0;
			end else if (hold_go && !hold_done) begin
				hold_done = 1'b1;
				hold_left = 400;
				m_axis_tready = 1'b0;
			end else begin
				m_axis_tready = steady || $urandom_range(99) >= 27;
			end
		end
	end

	function automatic logic [LVL_W-1:0] start_level(logic [OFFSET_W-1:0] off);
		int unsigned va_bits;
		va_bits = 64 - off;
		if (va_bits > 39)
			return LVL_0;
		if (va_bits > 30)
			return LVL_1;
		if (va_bits > 21)
			return LVL_2;
		return LVL_3;
	endfunction

	function automatic logic [DESC_W-1:0] rand_desc();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [ADDR_W-1:0] pick_va();
		int unsigned r;
		r = $urandom_range(15);
		if (r == 0)
			return '1;
		if (r == 1)
			return '0;
		return ADDR_W'({$urandom(), $urandom()});
	endfunction

	task automatic send_item(opcode_t op, logic [ADDR_W-1:0] va, logic [DESC_W-1:0] desc,
			logic failed);
		@(negedge clk);
		while (!steady && $urandom_range(99) < 27) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tuser = op;
		s_axis_tdata = {7'd0, failed, desc, va};
		do
			@(posedge clk);
		while (!s_axis_tready);
		sent++;
	endtask

	task automatic drain();
		int unsigned waited;
		waited = 0;
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (pending != 0 && waited < 10000) begin
			@(negedge clk);
			waited++;
		end
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(reg_index_t idx, logic [ADDR_W-1:0] value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_addr = idx;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic configure(int unsigned k);
		logic [ADDR_W-1:0] base;
		logic [ADDR_W-1:0] off_word;
		int offsets[8] = '{63, 0, 25, 34, 33, 42, 43, 16};
		case (k % 3)
			0: base = '1;
			1: base = '0;
			default: base = ADDR_W'({$urandom(), $urandom()});
		endcase
		off_word = ADDR_W'({$urandom(), $urandom()});
		off_word[OFFSET_W-1:0] = (k < 8) ? OFFSET_W'(offsets[k]) : OFFSET_W'($urandom());
		write_reg(REG_TABLE_BASE, base);
		write_reg(REG_VA_SIZE_OFFSET, off_word);
		cur_off = off_word[OFFSET_W-1:0];
		phases++;
	endtask

	// one walk with random outcomes; may be cut short to leave the walk running
	task automatic run_walk();
		logic [LVL_W-1:0] lvl;
		logic [DESC_W-1:0] d;
		int unsigned r;
		logic done;
		lvl = start_level(cur_off);
		walks++;
		send_item(OP_START, pick_va(), rand_desc(), 1'($urandom()));
		walk_open = 1'b1;
		done = 1'b0;
		while (!done) begin
			r = $urandom_range(99);
			d = rand_desc();
			if (r < 4) begin
				return;
			end else if (r < 10) begin
				send_item(OP_RESPONSE, pick_va(), d, 1'b1);
				done = 1'b1;
			end else if (r < 20) begin
				d[0] = 1'b0;
				send_item(OP_RESPONSE, pick_va(), d, 1'b0);
				done = 1'b1;
			end else if (lvl != LVL_3) begin
				if (r < 70) begin
					d[1:0] = 2'b11;
					send_item(OP_RESPONSE, pick_va(), d, 1'b0);
					lvl = lvl + 2'd1;
				end else begin
					d[1:0] = 2'b01;
					send_item(OP_RESPONSE, pick_va(), d, 1'b0);
					done = 1'b1;
				end
			end else begin
				d[1:0] = (r < 80) ? 2'b11 : 2'b01;
				send_item(OP_RESPONSE, pick_va(), d, 1'b0);
				done = 1'b1;
			end
		end
		walk_open = 1'b0;
	endtask

	initial begin
		int unsigned rand_start;
		int unsigned last_cfg;
		int unsigned setting;
		int unsigned waited;
		int unsigned n;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// reset settings: walks start at level 0 from a zero base
		send_item(OP_START, '1, '1, 1'b1);
		send_item(OP_RESPONSE, '0, '1, 1'b0);
		send_item(OP_RESPONSE, '0, 64'h0000_0000_0123_4003, 1'b0);
		send_item(OP_RESPONSE, '0, 64'hffff_0000_0abc_d003, 1'b0);
		send_item(OP_RESPONSE, '0, '1, 1'b0);
		send_item(OP_RESPONSE, '0, 64'h5a5a_5a5a_5a5a_5a5a, 1'b0);
		send_item(OP_START, '0, '0, 1'b0);
		send_item(OP_RESPONSE, '0, 64'h0060_8000_0000_0f81, 1'b0);
		send_item(OP_START, 48'h8123_4567_89ab, '0, 1'b0);
		send_item(OP_RESPONSE, '0, 64'h0000_0000_0000_5003, 1'b0);
		send_item(OP_RESPONSE, '0, 64'hffff_ffff_ffff_fffd, 1'b0);
		send_item(OP_START, 48'h7fff_ffff_ffff, '0, 1'b0);
		send_item(OP_RESPONSE, '0, 64'h0000_1234_5678_9003, 1'b0);
		send_item(OP_RESPONSE, '0, 64'h0000_0000_0000_7003, 1'b0);
		send_item(OP_RESPONSE, '0, 64'h0000_0000_0000_0001, 1'b0);
		send_item(OP_START, 48'h0000_0000_1000, '0, 1'b0);
		send_item(OP_RESPONSE, '0, 64'hffff_ffff_ffff_fffe, 1'b0);
		send_item(OP_START, 48'h0123_0000_0000, '0, 1'b0);
		send_item(OP_START, 48'h00ff_fff0_0fff, '1, 1'b0);
		send_item(OP_RESPONSE, '0, 64'h0000_0000_0000_1003, 1'b0);
		send_item(OP_RESPONSE, '0, 64'h0000_0000_0000_2003, 1'b0);
		send_item(OP_RESPONSE, '0, 64'h0000_0000_0000_3003, 1'b0);
		send_item(OP_RESPONSE, '0, 64'h0000_0000_0000_0001, 1'b0);
		send_item(OP_START, 48'h0000_dead_beef, '0, 1'b0);
		send_item(OP_RESPONSE, '0, '1, 1'b1);
		send_item(OP_RESPONSE, '1, '0, 1'b1);

		drain();
		setting = 0;
		configure(setting++);
		rand_start = sent;
		last_cfg = sent;
		while (sent - rand_start < 1200) begin
			n = sent - rand_start;
			steady = (n >= 300 && n < 500) || (n >= 600 && n < 750);
			hold_go = n >= 600;
			if (sent - last_cfg >= 150) begin
				drain();
				configure(setting++);
				last_cfg = sent;
			end
			if ($urandom_range(99) < 10) begin
				if (walk_open)
					run_walk();
				else
					send_item(OP_RESPONSE, pick_va(), rand_desc(), 1'($urandom()));
			end else begin
				run_walk();
			end
		end
		steady = 1'b0;

		@(negedge clk);
		s_axis_tvalid = 1'b0;
		waited = 0;
		while (pending != 0 && waited < 20000) begin
			@(negedge clk);
			waited++;
		end
		repeat (10) @(negedge clk);

		$display("run: %0d requests in %0d walks over %0d register settings", sent, walks,
			phases + 1);
		$display("run: %0d results checked, %0d of them translations", results, translations);
		if (errors == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
